// File: sv/cfpu_pkg.sv
// Shared types, codes and character constants for the console frequency
// command parser. No dependencies.
package cfpu_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned FREQ_W  = 32;
   localparam int unsigned CMD_W   = 3;
   localparam int unsigned VLEN_W  = 3;
   localparam int unsigned DCNT_W  = 4;
   localparam int unsigned MAC_W   = FREQ_W + 4;

   localparam logic [FREQ_W-1:0] BAND_LOW_RESET  = 32'd902000000;
   localparam logic [FREQ_W-1:0] BAND_HIGH_RESET = 32'd928000000;

   localparam logic [VLEN_W-1:0] VERB_LEN_WORD = 3'd4;
   localparam logic [VLEN_W-1:0] VERB_LEN_SAT  = 3'd5;
   localparam logic [DCNT_W-1:0] DIGITS_MAX    = 4'd10;
   localparam logic [DCNT_W-1:0] DIGITS_SAT    = 4'd11;

   // csr register indexes
   typedef enum logic [0:0] {
      REG_BAND_LOW  = 1'b0,
      REG_BAND_HIGH = 1'b1
   } reg_index_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_EMPTY   = 3'd0,
      CMD_HELP    = 3'd1,
      CMD_SHOW    = 3'd2,
      CMD_SET     = 3'd3,
      CMD_BAD     = 3'd4,
      CMD_UNKNOWN = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      PH_LEAD = 2'd0,
      PH_VERB = 2'd1,
      PH_GAP  = 2'd2,
      PH_ARG  = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic [VLEN_W-1:0]  verb_len;
      logic               help_ok;
      logic               freq_ok;
      logic [DCNT_W-1:0]  digit_cnt;
      logic [FREQ_W-1:0]  accum;
      logic               arg_invalid;
      logic               space_after;
      logic               nul_seen;
   } line_state_type;

   localparam line_state_type LINE_CLEAR = '{
      phase:       PH_LEAD,
      verb_len:    '0,
      help_ok:     1'b1,
      freq_ok:     1'b1,
      digit_cnt:   '0,
      accum:       '0,
      arg_invalid: 1'b0,
      space_after: 1'b0,
      nul_seen:    1'b0
   };

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
   endfunction

   function automatic logic [CHAR_W-1:0] help_char(input logic [1:0] idx);
      logic [CHAR_W-1:0] r;
      case (idx)
         2'd0: r = "h";
         2'd1: r = "e";
         2'd2: r = "l";
         default: r = "p";
      endcase
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] freq_char(input logic [1:0] idx);
      logic [CHAR_W-1:0] r;
      case (idx)
         2'd0: r = "f";
         2'd1: r = "r";
         2'd2: r = "e";
         default: r = "q";
      endcase
      return r;
   endfunction

endpackage

// File: sv/cfpu_line_state.sv
// Per-line parse state: registers plus the one-character update.
// Depends on cfpu_pkg.
module cfpu_line_state (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic [7:0]              ch,
   input  logic                    last,
   output cfpu_pkg::line_state_type state_nx
);
   import cfpu_pkg::*;

   line_state_type    state_ff;
   line_state_type    state_in;
   line_state_type    nx;
   logic [MAC_W-1:0]  mac;
   logic              is_digit;
   logic [DCNT_W-1:0] dcnt_inc;

   // accum * 10 + digit
   assign mac = {1'b0, state_ff.accum, 3'b000} + {3'b000, state_ff.accum, 1'b0}
              + {{(MAC_W-4){1'b0}}, ch[3:0]};
   assign is_digit = (ch >= "0") && (ch <= "9");
   assign dcnt_inc = (state_ff.digit_cnt < DIGITS_SAT) ? state_ff.digit_cnt + 4'd1
                                                        : state_ff.digit_cnt;

   always_comb begin
      logic do_verb;
      logic do_arg;
      do_verb = 1'b0;
      do_arg  = 1'b0;
      nx      = state_ff;
      if (!state_ff.nul_seen) begin
         if (ch == 8'h00) begin
            nx.nul_seen = 1'b1;
         end else begin
            case (state_ff.phase)
               PH_LEAD: begin
                  if (!is_blank(ch)) begin
                     nx.phase = PH_VERB;
                     do_verb  = 1'b1;
                  end
               end
               PH_VERB: begin
                  if (is_blank(ch)) nx.phase = PH_GAP;
                  else do_verb = 1'b1;
               end
               PH_GAP: begin
                  if (!is_blank(ch)) begin
                     nx.phase = PH_ARG;
                     do_arg   = 1'b1;
                  end
               end
               default: do_arg = 1'b1;
            endcase
         end
      end

      if (do_verb) begin
         if (state_ff.verb_len < VERB_LEN_WORD) begin
            if (ch != help_char(state_ff.verb_len[1:0])) nx.help_ok = 1'b0;
            if (ch != freq_char(state_ff.verb_len[1:0])) nx.freq_ok = 1'b0;
         end
         if (state_ff.verb_len < VERB_LEN_SAT) nx.verb_len = state_ff.verb_len + 3'd1;
      end

      if (do_arg) begin
         if (is_blank(ch)) begin
            nx.space_after = 1'b1;
         end else if (state_ff.space_after || !is_digit) begin
            nx.arg_invalid = 1'b1;
         end else begin
            nx.digit_cnt = dcnt_inc;
            if (dcnt_inc > DIGITS_MAX) begin
               nx.arg_invalid = 1'b1;
            end else if (!state_ff.arg_invalid) begin
               if (mac[MAC_W-1:FREQ_W] != '0) nx.arg_invalid = 1'b1;
               else nx.accum = mac[FREQ_W-1:0];
            end
         end
      end
   end

   assign state_nx = nx;
   assign state_in = last ? LINE_CLEAR : nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LINE_CLEAR;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/cfpu_classify.sv
// Line classification from the final parse state and the band limits.
// Depends on cfpu_pkg.
module cfpu_classify (
   input  cfpu_pkg::line_state_type state,
   input  logic [31:0]              band_low,
   input  logic [31:0]              band_high,
   output cfpu_pkg::cmd_type        command,
   output logic [31:0]              freq_hz
);
   import cfpu_pkg::*;

   logic word_len;
   logic value_ok;

   assign word_len = (state.verb_len == VERB_LEN_WORD);
   assign value_ok = !state.arg_invalid && (state.digit_cnt != '0)
                   && (state.digit_cnt <= DIGITS_MAX)
                   && (state.accum >= band_low) && (state.accum <= band_high);

   always_comb begin
      command = CMD_UNKNOWN;
      freq_hz = '0;
      if (state.phase == PH_LEAD) begin
         command = CMD_EMPTY;
      end else if (word_len && state.help_ok) begin
         command = (state.phase == PH_ARG) ? CMD_UNKNOWN : CMD_HELP;
      end else if (word_len && state.freq_ok) begin
         if (state.phase != PH_ARG) begin
            command = CMD_SHOW;
         end else if (value_ok) begin
            command = CMD_SET;
            freq_hz = state.accum;
         end else begin
            command = CMD_BAD;
         end
      end
   end

endmodule

// File: sv/console_freq_command_parser_unit.sv
// Top level of the console frequency command parser: input register,
// line-state update, classification and result register.
// Depends on cfpu_pkg, cfpu_line_state, cfpu_classify.
//
//  port group | dir | payload                                | request taken when
//  req_*      | in  | tdata[7:0] ch, tlast end_of_line       | req_tvalid & req_tready
//  rsp_*      | out | tdata[2:0] command, [34:3] freq_hz     | rsp_tvalid & rsp_tready
//  csr_*      | in  | index 0 band_low_hz, 1 band_high_hz    | csr_we
//
// One character per cycle sustained, except while an end-of-line char stalls. A
// request is first held in the input register; the line-state update and (on end
// of line) classification then load the result register, which drives rsp_tvalid.
// Only an end-of-line character stalls, and only while a previous result is
// still held in the result register and not taken in that cycle; other
// characters keep flowing.
// Reset (synchronous) clears the line state and both valid flags and sets the band registers.
module console_freq_command_parser_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // end_of_line
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [2:0] command, [34:3] freq_hz, [39:35] zero
   // register writes
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import cfpu_pkg::*;

   // input register
   logic              in_valid_ff;
   logic [CHAR_W-1:0] in_ch_ff;
   logic              in_last_ff;

   // band registers
   logic [FREQ_W-1:0] band_low_ff;
   logic [FREQ_W-1:0] band_high_ff;

   // result register
   logic              out_valid_ff;
   cmd_type           out_cmd_ff;
   logic [FREQ_W-1:0] out_freq_ff;

   logic              step_en;
   line_state_type    line_nx;
   cmd_type           cls_cmd;
   logic [FREQ_W-1:0] cls_freq;

   // A held end-of-line char waits only if the result slot is occupied and not being taken.
   assign step_en    = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ch_ff   <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_low_ff  <= BAND_LOW_RESET;
         band_high_ff <= BAND_HIGH_RESET;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_BAND_LOW:  band_low_ff  <= csr_wdata;
            REG_BAND_HIGH: band_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   cfpu_line_state u_line (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .ch       (in_ch_ff),
      .last     (in_last_ff),
      .state_nx (line_nx)
   );

   cfpu_classify u_cls (
      .state     (line_nx),
      .band_low  (band_low_ff),
      .band_high (band_high_ff),
      .command   (cls_cmd),
      .freq_hz   (cls_freq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_en && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && in_last_ff) begin
         out_cmd_ff  <= cls_cmd;
         out_freq_ff <= cls_freq;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b00000, out_freq_ff, out_cmd_ff};

`ifndef SYNTHESIS
   a_eol_gives_result: assert property (@(posedge clock) disable iff (reset)
      step_en && in_last_ff |=> rsp_tvalid)
      else $error("end of line did not load a result");

   a_set_in_band: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (out_cmd_ff == CMD_SET) |->
         (out_freq_ff >= band_low_ff) && (out_freq_ff <= band_high_ff))
      else $error("set result outside band");

   a_freq_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (out_cmd_ff != CMD_SET) |-> (out_freq_ff == '0))
      else $error("nonzero frequency on non-set result");

   a_eol_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_last_ff && rsp_tvalid && !rsp_tready |-> !req_tready && !step_en)
      else $error("end of line advanced over a held result");

   a_cmd_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (out_cmd_ff == CMD_SET) |-> (out_freq_ff != '0) || (band_low_ff == '0))
      else $error("zero set frequency with nonzero band floor");
`endif

endmodule

// File: verif/cfpu_line_checker.sv
`timescale 1ns / 1ps
// Line verdict checker for the console frequency command parser: mirrors band
// writes, predicts each line's command and frequency, compares responses.
// Depends on cfpu_pkg.
module cfpu_line_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);
   import cfpu_pkg::*;

   typedef struct packed {
      cmd_type           command;
      logic [FREQ_W-1:0] freq_hz;
   } verdict_type;

   localparam logic [31:0]       HELP_WORD  = "help";
   localparam logic [31:0]       FREQ_WORD  = "freq";
   localparam logic [CHAR_W-1:0] ASCII_ZERO = "0";
   localparam logic [CHAR_W-1:0] ASCII_NINE = "9";
   localparam logic [CHAR_W-1:0] ASCII_NUL  = 8'h00;

   verdict_type       expected_verdicts[$];
   logic [FREQ_W-1:0] band_low, band_high;

   // running view of the line in progress
   phase_type         line_phase;
   logic [VLEN_W-1:0] verb_len;
   logic              help_match, freq_match;
   logic [DCNT_W-1:0] digit_cnt;
   logic [FREQ_W-1:0] value_hz;
   logic              arg_bad, arg_gap, text_done;
   int                errors = 0;

   function automatic logic is_ws(input logic [CHAR_W-1:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
   endfunction

   task automatic clear_line();
      line_phase = PH_LEAD;
      verb_len   = '0;
      help_match = 1'b1;
      freq_match = 1'b1;
      digit_cnt  = '0;
      value_hz   = '0;
      arg_bad    = 1'b0;
      arg_gap    = 1'b0;
      text_done  = 1'b0;
   endtask

   task automatic verb_letter(input logic [CHAR_W-1:0] c);
      if (verb_len < VERB_LEN_WORD) begin
         if (c != HELP_WORD[8*(3-verb_len) +: 8]) help_match = 1'b0;
         if (c != FREQ_WORD[8*(3-verb_len) +: 8]) freq_match = 1'b0;
      end
      if (verb_len < VERB_LEN_SAT) verb_len = verb_len + 1'b1;
   endtask

   task automatic arg_letter(input logic [CHAR_W-1:0] c);
      logic [MAC_W-1:0] next_value;
      if (is_ws(c)) begin
         arg_gap = 1'b1;
         return;
      end
      if (arg_gap || c < ASCII_ZERO || c > ASCII_NINE) begin
         arg_bad = 1'b1;
         return;
      end
      if (digit_cnt < DIGITS_SAT) digit_cnt = digit_cnt + 1'b1;
      if (digit_cnt > DIGITS_MAX) begin
         arg_bad = 1'b1;
         return;
      end
      if (!arg_bad) begin
         next_value = {{(MAC_W-FREQ_W){1'b0}}, value_hz} * 10 + (c - ASCII_ZERO);
         if (next_value[MAC_W-1:FREQ_W] != '0) arg_bad = 1'b1;
         else value_hz = next_value[FREQ_W-1:0];
      end
   endtask

   task automatic absorb_char(input logic [CHAR_W-1:0] c);
      if (text_done) return;
      if (c == ASCII_NUL) begin
         text_done = 1'b1;
         return;
      end
      case (line_phase)
         PH_LEAD: if (!is_ws(c)) begin
            line_phase = PH_VERB;
            verb_letter(c);
         end
         PH_VERB: if (is_ws(c)) line_phase = PH_GAP;
                  else verb_letter(c);
         PH_GAP: if (!is_ws(c)) begin
            line_phase = PH_ARG;
            arg_letter(c);
         end
         default: arg_letter(c);
      endcase
   endtask

   function automatic verdict_type line_verdict();
      verdict_type v;
      v.freq_hz = '0;
      if (line_phase == PH_LEAD) begin
         v.command = CMD_EMPTY;
      end else if (verb_len == VERB_LEN_WORD && help_match) begin
         v.command = (line_phase == PH_ARG) ? CMD_UNKNOWN : CMD_HELP;
      end else if (verb_len == VERB_LEN_WORD && freq_match) begin
         if (line_phase != PH_ARG) begin
            v.command = CMD_SHOW;
         end else if (!arg_bad && digit_cnt >= 1 && digit_cnt <= DIGITS_MAX &&
                      value_hz >= band_low && value_hz <= band_high) begin
            v.command = CMD_SET;
            v.freq_hz = value_hz;
         end else begin
            v.command = CMD_BAD;
         end
      end else begin
         v.command = CMD_UNKNOWN;
      end
      return v;
   endfunction

   always @(posedge clock) begin : watch
      verdict_type       want;
      logic [CMD_W-1:0]  got_cmd;
      logic [FREQ_W-1:0] got_hz;
      if (reset) begin
         band_low  = BAND_LOW_RESET;
         band_high = BAND_HIGH_RESET;
         clear_line();
         expected_verdicts.delete();
      end else begin
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_BAND_LOW:  band_low  = csr_wdata;
               REG_BAND_HIGH: band_high = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            absorb_char(req_tdata);
            if (req_tlast) begin
               expected_verdicts.push_back(line_verdict());
               clear_line();
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got_cmd = rsp_tdata[CMD_W-1:0];
            got_hz  = rsp_tdata[CMD_W +: FREQ_W];
            if (expected_verdicts.size() == 0) begin
               $error("response with no line pending: command %0d, freq_hz %0d",
                      got_cmd, got_hz);
               errors++;
            end else begin
               want = expected_verdicts.pop_front();
               if (got_cmd !== want.command) begin
                  $error("command: expected %0d, got %0d", want.command, got_cmd);
                  errors++;
               end
               if (got_hz !== want.freq_hz) begin
                  $error("freq_hz: expected %0d, got %0d", want.freq_hz, got_hz);
                  errors++;
               end
            end
         end
      end
      fail_count    <= errors;
      pending_count <= expected_verdicts.size();
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Testbench top for console_freq_command_parser_unit: drives console lines and
// band writes, stalls the response side, reports the verdict.
// Depends on cfpu_pkg, console_freq_command_parser_unit and cfpu_line_checker.
module tb;
   import cfpu_pkg::*;

   typedef logic [CHAR_W-1:0] char_type;

   // response-side back-pressure styles, switched every so often
   typedef enum logic [1:0] {
      SINK_FREE   = 2'd0,
      SINK_RANDOM = 2'd1,
      SINK_SLOW   = 2'd2,
      SINK_TOGGLE = 2'd3
   } sink_mode_type;

   localparam char_type ASCII_SPACE = 8'h20;
   localparam char_type ASCII_TAB   = 8'h09;
   localparam char_type ASCII_CR    = 8'h0D;
   localparam char_type ASCII_LF    = 8'h0A;
   localparam char_type ASCII_NUL   = 8'h00;
   localparam char_type ASCII_ZERO  = "0";

   localparam int CHARS_PER_SETTING = 110;
   localparam int SETTING_COUNT     = 6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   int fail_count;
   int pending_count;

   // stimulus bookkeeping
   char_type          line_buf[$];
   logic [FREQ_W-1:0] band_lo = BAND_LOW_RESET;
   logic [FREQ_W-1:0] band_hi = BAND_HIGH_RESET;
   int                chars_sent = 0;
   int                lines_sent = 0;
   int                burst_left = 0;

   sink_mode_type sink_mode = SINK_FREE;
   int            sink_timer = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   console_freq_command_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   cfpu_line_checker verdict_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Response side: hold one stall style for a random stretch, then pick
   // another. Free-running stretches give runs with no stalls at all.
   always @(posedge clock) begin
      if (sink_timer == 0) begin
         sink_mode  <= sink_mode_type'($urandom_range(0, 3));
         sink_timer <= $urandom_range(20, 150);
      end else begin
         sink_timer <= sink_timer - 1;
      end
      case (sink_mode)
         SINK_FREE:   rsp_tready <= 1'b1;
         SINK_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
         SINK_SLOW:   rsp_tready <= ($urandom_range(0, 7) == 0);
         default:     rsp_tready <= ~rsp_tready;
      endcase
   end

   // ---- line building ----

   function automatic void add_char(input char_type c);
      line_buf.push_back(c);
   endfunction

   function automatic void add_text(input string s);
      foreach (s[i]) line_buf.push_back(s[i]);
   endfunction

   function automatic char_type pick_blank();
      case ($urandom_range(0, 3))
         0: return ASCII_SPACE;
         1: return ASCII_TAB;
         2: return ASCII_CR;
         default: return ASCII_LF;
      endcase
   endfunction

   function automatic void add_blanks(input int n);
      repeat (n) add_char(pick_blank());
   endfunction

   // Argument aimed at the current band: both edges, one past each edge,
   // or anywhere inside. With an inverted band nothing can pass anyway.
   function automatic longint unsigned in_band_value();
      longint unsigned span;
      if (band_lo > band_hi) return {$urandom, $urandom} % 64'd5_000_000_000;
      span = {32'b0, band_hi} - {32'b0, band_lo} + 64'd1;
      case ($urandom_range(0, 5))
         0: return {32'b0, band_lo};
         1: return {32'b0, band_hi};
         2: return {32'b0, band_lo} - 64'd1;   // wraps to 20 digits when low is 0
         3: return {32'b0, band_hi} + 64'd1;
         default: return {32'b0, band_lo} + ({$urandom, $urandom} % span);
      endcase
   endfunction

   // Arguments around the 32-bit and digit-count limits.
   function automatic longint unsigned odd_value();
      case ($urandom_range(0, 4))
         0: return 64'd0;
         1: return 64'hFFFF_FFFF;
         2: return 64'h1_0000_0000 + {32'b0, $urandom_range(0, 9)};
         3: return {$urandom, $urandom} % 64'd100_000_000_000;
         default: return {32'b0, $urandom};
      endcase
   endfunction

   function automatic string near_miss_text();
      case ($urandom_range(0, 11))
         0: return "hel";
         1: return "helpp";
         2: return "help me";
         3: return "Help";
         4: return "fre";
         5: return "freqq 915000000";
         6: return "frEq";
         7: return "freq12";
         8: return "freq 915 000";
         9: return "freq -5";
         10: return "freq 0x10";
         default: return "help\tfreq";
      endcase
   endfunction

   // Mostly well-formed commands with random content; some are damaged by
   // one random byte (NUL among them), a few are near misses or pure noise.
   task automatic make_random_line();
      int kind;
      int pos;
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 2) == 0) add_blanks($urandom_range(1, 3));
      if (kind < 8) begin
         add_blanks(1);
      end else if (kind < 18) begin
         add_text("help");
      end else if (kind < 28) begin
         add_text("freq");
      end else if (kind < 85) begin
         add_text("freq");
         add_blanks($urandom_range(1, 2));
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) add_char(ASCII_ZERO);
         add_text($sformatf("%0d", (kind < 60) ? in_band_value() : odd_value()));
         if (kind >= 75) begin
            pos = $urandom_range(0, line_buf.size() - 1);
            line_buf[pos] = ($urandom_range(0, 3) == 0) ? ASCII_NUL
                                                         : char_type'($urandom_range(0, 255));
         end
      end else if (kind < 93) begin
         add_text(near_miss_text());
      end else begin
         repeat ($urandom_range(1, 10)) add_char(char_type'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 2) == 0) add_blanks($urandom_range(1, 3));
   endtask

   // ---- request driving ----

   // One character per request; the sender runs in bursts with random gaps.
   task automatic send_char(input char_type c, input logic last);
      int idle;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (idle > 0) begin
            req_tvalid <= 1'b0;
            repeat (idle) @(posedge clock);
         end
      end
      burst_left = burst_left - 1;
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      chars_sent++;
   endtask

   // Sends the built line with the end flag on its last character.
   task automatic send_line();
      foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
      line_buf.delete();
      lines_sent++;
   endtask

   task automatic say(input string s);
      add_text(s);
      send_line();
   endtask

   // Stop sending and wait until every line has its response, then let the
   // two-stage pipe settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Both band registers, back to back; only called with the block idle.
   task automatic set_band(input logic [FREQ_W-1:0] lo, input logic [FREQ_W-1:0] hi);
      csr_we    <= 1'b1;
      csr_index <= REG_BAND_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= REG_BAND_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we <= 1'b0;
      band_lo = lo;
      band_hi = hi;
   endtask

   initial begin : stimulus
      int          target;
      bit          paused;
      logic [31:0] lo;
      paused = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed lines, reset band 902..928 MHz
      add_char(ASCII_SPACE);
      send_line();                      // blank line
      say("help");
      say("freq");
      say("freq 915000000");
      say("freq 902000000");            // band edges
      say("freq 928000000");
      say("freq 901999999");            // just outside
      say("freq 928000001");
      say("freq 4294967295");           // max value, out of band
      say("freq 4294967296");           // overflow
      say("freq 00915000000");          // 11 digits
      say("freq 0915000000");           // 10 digits with a leading zero
      say("freq 915 000");              // space inside the argument
      say("freq 9150000x0");
      say("help me");
      say("helpx");
      say("freqs 1");
      add_char(ASCII_TAB);
      add_text("  freq");
      add_char(ASCII_TAB);
      add_text("915000000");
      add_char(ASCII_CR);
      add_char(ASCII_LF);
      send_line();                      // surrounding whitespace
      add_text("fre");
      add_char(ASCII_NUL);
      add_text("q");
      send_line();                      // NUL cuts the verb short
      add_char(ASCII_NUL);
      add_text("help");
      send_line();                      // NUL first: nothing left
      add_text("freq 915000000");
      add_char(ASCII_NUL);
      add_text("junk");
      send_line();                      // tail after NUL ignored
      add_char(8'hFF);
      add_char(8'h80);
      send_line();
      add_text("freq");
      add_char(ASCII_TAB);
      add_text("   ");
      send_line();                      // verb with trailing blanks only

      // random lines over several band settings
      for (int setting = 0; setting < SETTING_COUNT; setting++) begin
         if (setting != 0) begin
            drain();
            case (setting)
               1: set_band(32'd0, 32'hFFFF_FFFF);
               2: set_band(32'd0, 32'd0);
               3: set_band(32'hFFFF_FFFF, 32'hFFFF_FFFF);
               4: set_band(BAND_HIGH_RESET, BAND_LOW_RESET);   // inverted
               default: begin
                  lo = $urandom;
                  set_band(lo, (lo > 32'hFFFF_FFFF - 32'd1_000_000) ? 32'hFFFF_FFFF
                                : lo + $urandom_range(0, 1_000_000));
               end
            endcase
         end
         target = chars_sent + CHARS_PER_SETTING;
         while (chars_sent < target) begin
            make_random_line();
            send_line();
            // one full pause mid-stream with nothing outstanding
            if (setting == 0 && !paused && chars_sent > target - CHARS_PER_SETTING / 2) begin
               drain();
               paused = 1'b1;
            end
         end
      end

      drain();
      $display("lines sent: %0d (%0d characters) over %0d band settings", lines_sent,
               chars_sent, SETTING_COUNT);
      $display("bands: reset, full range, zero only, max only, inverted, random narrow");
      if (fail_count == 0) begin
         $display("console_freq_command_parser_unit: match");
      end else begin
         $display("console_freq_command_parser_unit: mismatch");
      end
      $finish;
   end

   // run limit, far above the slowest legal run
   initial begin
      #2_000_000;
      $display("run limit reached with %0d lines still open", pending_count);
      $display("console_freq_command_parser_unit: mismatch");
      $finish;
   end

endmodule

// File: filelist.f
sv/cfpu_pkg.sv
sv/cfpu_line_state.sv
sv/cfpu_classify.sv
sv/console_freq_command_parser_unit.sv
verif/cfpu_line_checker.sv
verif/tb.sv
